[rtl/wpd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package wpd_pkg;

  // Configuration register map
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 20;
  localparam logic [CFG_INDEX_W-1:0] CFG_DEVIATION_LIMIT = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_START_INDEX     = 1'd1;

  localparam int LIMIT_W = 20;
  localparam int START_W = 16;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 20'd16;
  localparam logic [START_W-1:0] START_RESET = 16'd25;

  // Deviation test: 128 * (d1^2 + d2^2 + d3^2) > 3 * limit^2.
  // A pairwise difference at or above 2^BIG_SHIFT passes at once.
  localparam int BIG_SHIFT   = 18;
  localparam int DIFF_W      = BIG_SHIFT;
  localparam int SQ_W        = 2 * DIFF_W;
  localparam int SUM_W       = SQ_W + 2;
  localparam int SCALE_SHIFT = 7;
  localparam int TEST_W      = SUM_W + SCALE_SHIFT;
  localparam int LIMIT_SQ_W  = 2 * LIMIT_W;
  localparam int THR_W       = LIMIT_SQ_W + 2;

  localparam logic [LIMIT_SQ_W-1:0] LIMIT_SQ_RESET = LIMIT_SQ_W'(256);
  localparam logic [THR_W-1:0]      THR_RESET      = THR_W'(768);

  // Full windows skipped after a peak
  localparam int SKIP_W = 2;
  localparam logic [SKIP_W-1:0] SKIP_AFTER = 2'd2;

  typedef struct packed {
    logic clr;   // first word of a profile
    logic win;   // word completes a full window
    logic cand;  // shape and start index qualify
    logic big;   // some difference is large enough to pass outright
  } win_ctl_t;

  typedef struct packed {
    logic clr;
    logic win;
    logic hit;   // shape, start index and deviation all qualify
  } dec_ctl_t;

endpackage

`default_nettype wire

[rtl/window_peak_detector.sv]
`timescale 1ns / 1ps
`default_nettype none
// A peak_index word appears at peak_valid once its sample has passed all four registers.
// Throughput: one sample word per cycle, set by the four-register pipeline
//   (window, squares, sum/compare, output); a waiting result holds back every full stage
//   behind it, so sample_ready drops only once the bubbles ahead of the input are used up.
// deviation_limit reaches the compare through limit_sq (squared), then threshold (x3).
// Reset (rst, synchronous): window, index and skip count cleared, pipeline emptied,
//   deviation_limit = 16, start_index = 25.
module window_peak_detector #(
  parameter int SAMPLE_BITS = 16,
  parameter int INDEX_BITS  = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // sample stream
  input  wire logic                             sample_valid,
  output logic                                  sample_ready,
  input  wire logic [SAMPLE_BITS-1:0]           sample,
  input  wire logic                             first_of_profile,
  // peak stream
  output logic                                  peak_valid,
  input  wire logic                             peak_ready,
  output logic [INDEX_BITS-1:0]                 peak_index,
  // configuration writes
  input  wire logic                             cfg_write_en,
  input  wire logic [wpd_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [wpd_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import wpd_pkg::*;

  logic [LIMIT_W-1:0]     deviation_limit;
  logic [START_W-1:0]     start_index;
  logic [LIMIT_SQ_W-1:0]  limit_sq;
  logic [THR_W-1:0]       threshold;

  logic                   s1_valid;
  win_ctl_t               s1_ctl;
  logic [INDEX_BITS-1:0]  s1_index;
  logic [2:0][DIFF_W-1:0] s1_diff;
  logic                   dev_ready;
  logic                   s3_valid;
  dec_ctl_t               s3_ctl;
  logic [INDEX_BITS-1:0]  s3_index;
  logic                   out_free;

  // Config registers. The threshold 3 * limit^2 is kept precomputed so the
  // compare stage sees a plain register; it trails the limit through limit_sq.
  always_ff @(posedge clk) begin
    if (rst) begin
      deviation_limit <= LIMIT_RESET;
      start_index     <= START_RESET;
      limit_sq        <= LIMIT_SQ_RESET;
      threshold       <= THR_RESET;
    end else begin
      if (cfg_write_en) begin
        case (cfg_index)
          CFG_DEVIATION_LIMIT: deviation_limit <= cfg_data[LIMIT_W-1:0];
          CFG_START_INDEX:     start_index     <= cfg_data[START_W-1:0];
          default: ;
        endcase
      end
      limit_sq  <= LIMIT_SQ_W'(deviation_limit) * LIMIT_SQ_W'(deviation_limit);
      threshold <= THR_W'(limit_sq) + (THR_W'(limit_sq) << 1);
    end
  end

  // Window state, shape and start checks, pairwise differences
  wpd_window #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .INDEX_BITS  (INDEX_BITS)
  ) u_window (
    .clk              (clk),
    .rst              (rst),
    .sample_valid     (sample_valid),
    .sample_ready     (sample_ready),
    .sample           (sample),
    .first_of_profile (first_of_profile),
    .start_index      (start_index),
    .down_ready       (dev_ready),
    .s1_valid         (s1_valid),
    .s1_ctl           (s1_ctl),
    .s1_index         (s1_index),
    .s1_diff          (s1_diff)
  );

  // Squares, then sum and threshold compare
  wpd_deviation #(
    .INDEX_BITS (INDEX_BITS)
  ) u_deviation (
    .clk        (clk),
    .rst        (rst),
    .s1_valid   (s1_valid),
    .s1_ctl     (s1_ctl),
    .s1_index   (s1_index),
    .s1_diff    (s1_diff),
    .threshold  (threshold),
    .up_ready   (dev_ready),
    .down_ready (out_free),
    .s3_valid   (s3_valid),
    .s3_ctl     (s3_ctl),
    .s3_index   (s3_index)
  );

  // Skip count after a peak, output register. Skip state sits at the end of
  // the pipeline so windows are resolved strictly in order.
  wpd_decide #(
    .INDEX_BITS (INDEX_BITS)
  ) u_decide (
    .clk        (clk),
    .rst        (rst),
    .s3_valid   (s3_valid),
    .s3_ctl     (s3_ctl),
    .s3_index   (s3_index),
    .out_free   (out_free),
    .peak_valid (peak_valid),
    .peak_ready (peak_ready),
    .peak_index (peak_index)
  );

endmodule

`default_nettype wire

[rtl/wpd_window.sv]
`timescale 1ns / 1ps
`default_nettype none

module wpd_window #(
  parameter int SAMPLE_BITS = 16,
  parameter int INDEX_BITS  = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 sample_valid,
  output logic                                      sample_ready,
  input  wire logic [SAMPLE_BITS-1:0]               sample,
  input  wire logic                                 first_of_profile,
  input  wire logic [wpd_pkg::START_W-1:0]          start_index,
  input  wire logic                                 down_ready,
  output logic                                      s1_valid,
  output wpd_pkg::win_ctl_t                         s1_ctl,
  output logic [INDEX_BITS-1:0]                     s1_index,
  output logic [2:0][wpd_pkg::DIFF_W-1:0]           s1_diff
);
  import wpd_pkg::*;

  localparam int WIDE_W = (SAMPLE_BITS > BIG_SHIFT) ? SAMPLE_BITS : BIG_SHIFT + 1;
  localparam int CMP_W  = (INDEX_BITS > START_W) ? INDEX_BITS : START_W;
  localparam logic [INDEX_BITS-1:0] INDEX_MAX = '1;

  function automatic logic [WIDE_W-1:0] abs_diff(input logic [WIDE_W-1:0] a,
                                                 input logic [WIDE_W-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  logic [SAMPLE_BITS-1:0] older_sample;
  logic [SAMPLE_BITS-1:0] middle_sample;
  logic [INDEX_BITS-1:0]  sample_count;

  logic [SAMPLE_BITS-1:0] older_eff;
  logic [SAMPLE_BITS-1:0] middle_eff;
  logic [INDEX_BITS-1:0]  n;
  logic [INDEX_BITS-1:0]  window_start;
  logic                   overflow;
  logic                   full_window;
  logic                   start_ok;
  logic                   shape_ok;
  logic [2:0][WIDE_W-1:0] wide_diff;
  logic                   any_big;
  logic                   accept;

  always_comb begin
    older_eff    = first_of_profile ? '0 : older_sample;
    middle_eff   = first_of_profile ? '0 : middle_sample;
    n            = first_of_profile ? '0 : sample_count;
    overflow     = (n == INDEX_MAX);
    full_window  = (n[INDEX_BITS-1:1] != '0);
    window_start = n - INDEX_BITS'(2);
    start_ok     = CMP_W'(window_start) >= CMP_W'(start_index);
    shape_ok     = (middle_eff > older_eff) && (middle_eff > sample);
    wide_diff[0] = abs_diff(WIDE_W'(older_eff), WIDE_W'(middle_eff));
    wide_diff[1] = abs_diff(WIDE_W'(middle_eff), WIDE_W'(sample));
    wide_diff[2] = abs_diff(WIDE_W'(older_eff), WIDE_W'(sample));
    any_big      = (|wide_diff[0][WIDE_W-1:BIG_SHIFT]) ||
                   (|wide_diff[1][WIDE_W-1:BIG_SHIFT]) ||
                   (|wide_diff[2][WIDE_W-1:BIG_SHIFT]);
  end

  assign sample_ready = !s1_valid || down_ready;
  assign accept       = sample_valid && sample_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      older_sample  <= '0;
      middle_sample <= '0;
      sample_count  <= '0;
    end else begin
      if (sample_ready) begin
        s1_valid <= sample_valid && !overflow;
      end
      if (accept && !overflow) begin
        older_sample  <= middle_eff;
        middle_sample <= sample;
        sample_count  <= n + INDEX_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sample_ready) begin
      s1_ctl.clr  <= first_of_profile;
      s1_ctl.win  <= full_window;
      s1_ctl.cand <= full_window && start_ok && shape_ok;
      s1_ctl.big  <= any_big;
      s1_index    <= n - INDEX_BITS'(1);
      s1_diff[0]  <= wide_diff[0][DIFF_W-1:0];
      s1_diff[1]  <= wide_diff[1][DIFF_W-1:0];
      s1_diff[2]  <= wide_diff[2][DIFF_W-1:0];
    end
  end

endmodule

`default_nettype wire

[rtl/wpd_deviation.sv]
`timescale 1ns / 1ps
`default_nettype none

module wpd_deviation #(
  parameter int INDEX_BITS = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s1_valid,
  input  wire wpd_pkg::win_ctl_t           s1_ctl,
  input  wire logic [INDEX_BITS-1:0]       s1_index,
  input  wire logic [2:0][wpd_pkg::DIFF_W-1:0] s1_diff,
  input  wire logic [wpd_pkg::THR_W-1:0]   threshold,
  output logic                             up_ready,
  input  wire logic                        down_ready,
  output logic                             s3_valid,
  output wpd_pkg::dec_ctl_t                s3_ctl,
  output logic [INDEX_BITS-1:0]            s3_index
);
  import wpd_pkg::*;

  logic                   s2_valid;
  win_ctl_t               s2_ctl;
  logic [INDEX_BITS-1:0]  s2_index;
  logic [2:0][SQ_W-1:0]   s2_sq;
  logic                   s3_ready;
  logic [SUM_W-1:0]       sum;
  logic                   exceeds;

  assign s3_ready = !s3_valid || down_ready;
  assign up_ready = !s2_valid || s3_ready;

  always_comb begin
    sum     = SUM_W'(s2_sq[0]) + SUM_W'(s2_sq[1]) + SUM_W'(s2_sq[2]);
    exceeds = {sum, SCALE_SHIFT'(0)} > TEST_W'(threshold);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (up_ready) begin
        s2_valid <= s1_valid;
      end
      if (s3_ready) begin
        s3_valid <= s2_valid;
      end
    end
  end

  // squares in parallel into s2, sum and compare into s3
  always_ff @(posedge clk) begin
    if (up_ready) begin
      s2_ctl   <= s1_ctl;
      s2_index <= s1_index;
      s2_sq[0] <= SQ_W'(s1_diff[0]) * SQ_W'(s1_diff[0]);
      s2_sq[1] <= SQ_W'(s1_diff[1]) * SQ_W'(s1_diff[1]);
      s2_sq[2] <= SQ_W'(s1_diff[2]) * SQ_W'(s1_diff[2]);
    end
    if (s3_ready) begin
      s3_ctl.clr <= s2_ctl.clr;
      s3_ctl.win <= s2_ctl.win;
      s3_ctl.hit <= s2_ctl.cand && (s2_ctl.big || exceeds);
      s3_index   <= s2_index;
    end
  end

endmodule

`default_nettype wire

[rtl/wpd_decide.sv]
`timescale 1ns / 1ps
`default_nettype none

module wpd_decide #(
  parameter int INDEX_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s3_valid,
  input  wire wpd_pkg::dec_ctl_t     s3_ctl,
  input  wire logic [INDEX_BITS-1:0] s3_index,
  output logic                       out_free,
  output logic                       peak_valid,
  input  wire logic                  peak_ready,
  output logic [INDEX_BITS-1:0]      peak_index
);
  import wpd_pkg::*;

  logic [SKIP_W-1:0] skip_count;
  logic [SKIP_W-1:0] skip_eff;
  logic [SKIP_W-1:0] skip_next;
  logic              take;
  logic              produce;

  assign out_free = !peak_valid || peak_ready;
  assign take     = s3_valid && out_free;

  always_comb begin
    skip_eff  = s3_ctl.clr ? '0 : skip_count;
    produce   = 1'b0;
    skip_next = skip_eff;
    if (s3_ctl.win) begin
      if (skip_eff != '0) begin
        skip_next = skip_eff - SKIP_W'(1);
      end else if (s3_ctl.hit) begin
        produce   = 1'b1;
        skip_next = SKIP_AFTER;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      skip_count <= '0;
      peak_valid <= 1'b0;
    end else begin
      if (take) begin
        skip_count <= skip_next;
      end
      if (out_free) begin
        peak_valid <= s3_valid && produce;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && produce) begin
      peak_index <= s3_index;
    end
  end

  a_peak_arms_skip: assert property (@(posedge clk) disable iff (rst)
    (take && produce) |=> (peak_valid && skip_count == SKIP_AFTER))
    else $error("peak did not arm the skip count");

  a_skip_counts_down: assert property (@(posedge clk) disable iff (rst)
    (take && !s3_ctl.clr && s3_ctl.win && skip_count != '0) |=>
    (skip_count == $past(skip_count) - SKIP_W'(1)))
    else $error("skipped window did not count down");

  a_skip_range: assert property (@(posedge clk) disable iff (rst)
    (skip_count <= SKIP_AFTER))
    else $error("skip count out of range");

endmodule

`default_nettype wire
